// ----- rtl/core/scgt_pkg.sv -----
// Package for the sorted code glyph table: commands, status codes, entry type.
// No dependencies.
`default_nettype none
package scgt_pkg;
  localparam int unsigned TableDepthDefault = 1024;
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_NEXT   = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;
  typedef struct packed {
    logic [31:0] code;
    logic [15:0] glyph;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/core/sorted_code_glyph_table.sv -----
// Top level of the sorted code glyph table: sequencer around one pair memory.
// Depends on scgt_pkg.
//
// One command is taken at a time and gives one result transaction. The table
// lives in one synchronous memory with a registered read, so every step of the
// binary search visits two states, S_SRCH and S_SWAIT. Next then skips entries
// with glyph zero one by one, insert shifts each larger entry up through S_SHIFT
// and S_SHWAIT before the final write, and clear goes straight to the result.
// No clearing pass follows reset.
`default_nettype none
module sorted_code_glyph_table #(
  parameter int unsigned TABLE_DEPTH = scgt_pkg::TableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // command[1:0], code[33:2], glyph_in[49:34], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // glyph_out[15:0], found_code[47:16], status[49:48], pad
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRCH   = 3'd1;
  localparam logic [2:0] S_SWAIT  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_SHWAIT = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  scgt_pkg::entry_t mem [TABLE_DEPTH];
  scgt_pkg::entry_t rd_q;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   code_r, code_nxt;
  logic [15:0]   glyph_r, glyph_nxt;
  logic [15:0]   g_out_r, g_out_nxt;
  logic [31:0]   c_out_r, c_out_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  scgt_pkg::entry_t wdata;
  logic [CW-1:0] mid;
  logic [CW:0]   mid_sum;
  logic          in_acc;

  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {6'd0, st_r, c_out_r, g_out_r};
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = mid_sum[CW:1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; lo_nxt = lo_r; hi_nxt = hi_r;
    pos_nxt = pos_r; cmd_nxt = cmd_r; key_nxt = key_r; code_nxt = code_r;
    glyph_nxt = glyph_r; g_out_nxt = g_out_r; c_out_nxt = c_out_r; st_nxt = st_r;
    we = 1'b0; waddr = pos_r[AW-1:0]; wdata = '{code: code_r, glyph: glyph_r};
    raddr = mid[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_tdata[1:0];
          code_nxt = in_tdata[33:2];
          glyph_nxt = in_tdata[49:34];
          key_nxt = (in_tdata[1:0] == scgt_pkg::CMD_NEXT) ? in_tdata[33:2] + 32'd1
                                                          : in_tdata[33:2];
          lo_nxt = '0; hi_nxt = count_r;
          g_out_nxt = '0; c_out_nxt = '0; st_nxt = scgt_pkg::ST_OK;
          state_nxt = S_SRCH;
          priority if (in_tdata[1:0] == scgt_pkg::CMD_CLEAR) begin
            count_nxt = '0; state_nxt = S_OUT;
          end else if (in_tdata[1:0] == scgt_pkg::CMD_INSERT && in_tdata[33:2] == 32'd0) begin
            st_nxt = scgt_pkg::ST_REJECT; state_nxt = S_OUT;
          end else if (in_tdata[1:0] == scgt_pkg::CMD_NEXT && in_tdata[33:2] == 32'hFFFFFFFF) begin
            st_nxt = scgt_pkg::ST_MISS; state_nxt = S_OUT;
          end
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          state_nxt = S_SWAIT;
        end else begin
          pos_nxt = lo_r;
          raddr = lo_r[AW-1:0];
          state_nxt = S_DECIDE;
        end
      end
      S_SWAIT: begin
        if (rd_q.code < key_r) lo_nxt = mid + CW'(1);
        else hi_nxt = mid;
        state_nxt = S_SRCH;
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        unique case (cmd_r)
          scgt_pkg::CMD_INSERT: begin
            if (pos_r < count_r && rd_q.code == code_r) st_nxt = scgt_pkg::ST_REJECT;
            else if (count_r >= DEPTH_C) st_nxt = scgt_pkg::ST_FULL;
            else begin
              pos_nxt = count_r;
              state_nxt = S_SHIFT;
            end
          end
          scgt_pkg::CMD_LOOKUP: begin
            if (pos_r < count_r && rd_q.code == code_r) g_out_nxt = rd_q.glyph;
            else st_nxt = scgt_pkg::ST_MISS;
          end
          scgt_pkg::CMD_NEXT: begin
            if (pos_r >= count_r) st_nxt = scgt_pkg::ST_MISS;
            else if (rd_q.glyph != 16'd0) begin
              g_out_nxt = rd_q.glyph; c_out_nxt = rd_q.code;
            end else begin
              pos_nxt = pos_r + CW'(1);
              raddr = AW'(pos_r + CW'(1));
              state_nxt = S_DECIDE;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SHIFT: begin
        if (pos_r == lo_r) begin
          we = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = S_OUT;
        end else begin
          raddr = AW'(pos_r - CW'(1));
          state_nxt = S_SHWAIT;
        end
      end
      S_SHWAIT: begin
        we = 1'b1;
        wdata = rd_q;
        pos_nxt = pos_r - CW'(1);
        state_nxt = S_SHIFT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; pos_r <= pos_nxt; cmd_r <= cmd_nxt;
    key_r <= key_nxt; code_r <= code_nxt; glyph_r <= glyph_nxt;
    g_out_r <= g_out_nxt; c_out_r <= c_out_nxt; st_r <= st_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("entry count above depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("ready while busy");
  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAIT |-> lo_r < hi_r) else $error("search window empty");
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for sorted_code_glyph_table: directed and random clear, insert, lookup and next.
// Depends on scgt_pkg and the sorted_code_glyph_table RTL; holds its own table predictor.
`timescale 1ns / 100ps
module tb_top;
  localparam int unsigned Depth = scgt_pkg::TableDepthDefault;

  typedef struct packed {
    logic [15:0] glyph;
    logic [31:0] code;
    logic [1:0]  status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  logic [31:0] tbl_code [Depth];
  logic [15:0] tbl_glyph [Depth];
  int unsigned tbl_count;
  answer_t     answer_queue [$];
  int unsigned error_count;
  bit          idle_enable;
  logic [31:0] used_codes [$];

  always #6 clk = ~clk;

  sorted_code_glyph_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic int unsigned first_not_below(logic [31:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_code[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic answer_t apply_command(logic [1:0] cmd, logic [31:0] code,
                                            logic [15:0] glyph);
    answer_t a;
    int unsigned pos;
    a = '0;
    case (cmd)
      scgt_pkg::CMD_CLEAR: tbl_count = 0;
      scgt_pkg::CMD_INSERT: begin
        pos = first_not_below(code);
        if (code == 0) a.status = scgt_pkg::ST_REJECT;
        else if (pos < tbl_count && tbl_code[pos] == code) a.status = scgt_pkg::ST_REJECT;
        else if (tbl_count >= Depth) a.status = scgt_pkg::ST_FULL;
        else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_code[i] = tbl_code[i-1];
            tbl_glyph[i] = tbl_glyph[i-1];
          end
          tbl_code[pos] = code;
          tbl_glyph[pos] = glyph;
          tbl_count++;
        end
      end
      scgt_pkg::CMD_LOOKUP: begin
        pos = first_not_below(code);
        if (pos < tbl_count && tbl_code[pos] == code) a.glyph = tbl_glyph[pos];
        else a.status = scgt_pkg::ST_MISS;
      end
      default: begin
        a.status = scgt_pkg::ST_MISS;
        if (code != 32'hFFFF_FFFF) begin
          for (pos = first_not_below(code + 32'd1); pos < tbl_count; pos++) begin
            if (tbl_glyph[pos] != 0) begin
              a.glyph = tbl_glyph[pos];
              a.code = tbl_code[pos];
              a.status = scgt_pkg::ST_OK;
              break;
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  task automatic send_command(logic [1:0] cmd, logic [31:0] code, logic [15:0] glyph);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, glyph, code, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    answer_queue.push_back(apply_command(cmd, code, glyph));
    if (cmd == scgt_pkg::CMD_INSERT) used_codes.push_back(code);
  endtask

  // Check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (answer_queue.size() == 0) report("unexpected result", out_tdata[31:0], 32'd0);
      else begin
        answer_t w;
        w = answer_queue.pop_front();
        if (out_tdata[15:0] !== w.glyph)
          report("glyph_out", 32'(out_tdata[15:0]), 32'(w.glyph));
        if (out_tdata[47:16] !== w.code) report("found_code", out_tdata[47:16], w.code);
        if (out_tdata[49:48] !== w.status)
          report("status", 32'(out_tdata[49:48]), 32'(w.status));
      end
    end
  end

  // Receiver stalls in bursts.
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 11);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (answer_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_code();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 40);
      1: if (used_codes.size() != 0)
           return used_codes[$urandom_range(0, used_codes.size() - 1)];
         else return $urandom;
      2: return $urandom;
      default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [15:0] pick_glyph();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_command(scgt_pkg::CMD_LOOKUP, 32'd5, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'd0, 16'd0);
    send_command(scgt_pkg::CMD_INSERT, 32'd0, 16'd7);
    send_command(scgt_pkg::CMD_INSERT, 32'd1, 16'hFFFF);
    send_command(scgt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hAAAA);
    send_command(scgt_pkg::CMD_INSERT, 32'h8000_0000, 16'd0);
    send_command(scgt_pkg::CMD_INSERT, 32'h5555_5555, 16'h5555);
    send_command(scgt_pkg::CMD_INSERT, 32'h8000_0000, 16'd3);
    send_command(scgt_pkg::CMD_LOOKUP, 32'h8000_0000, 16'd0);
    send_command(scgt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 16'd0);
    send_command(scgt_pkg::CMD_LOOKUP, 32'd2, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'h5555_5555, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'd0, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'hFFFF_FFFE, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'hFFFF_FFFF, 16'd0);
    send_command(scgt_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(scgt_pkg::CMD_LOOKUP, 32'd1, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'd0, 16'd0);
    drain();
  endtask

  task automatic test_fill_table();
    send_command(scgt_pkg::CMD_CLEAR, 32'd0, 16'd0);
    for (int i = 0; i < Depth; i++)
      send_command(scgt_pkg::CMD_INSERT, 32'd2 * (Depth - i), 16'(i + 1));
    send_command(scgt_pkg::CMD_INSERT, 32'd3, 16'd9);
    send_command(scgt_pkg::CMD_INSERT, 32'd4, 16'd9);
    send_command(scgt_pkg::CMD_INSERT, 32'd0, 16'd9);
    send_command(scgt_pkg::CMD_LOOKUP, 32'd2, 16'd0);
    send_command(scgt_pkg::CMD_LOOKUP, 32'd2 * Depth, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'd2 * Depth - 1, 16'd0);
    send_command(scgt_pkg::CMD_NEXT, 32'd2 * Depth, 16'd0);
    drain();
  endtask

  task automatic test_random(int unsigned count);
    logic [1:0] cmd;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) cmd = scgt_pkg::CMD_CLEAR;
      else if (r < 45) cmd = scgt_pkg::CMD_INSERT;
      else if (r < 75) cmd = scgt_pkg::CMD_LOOKUP;
      else cmd = scgt_pkg::CMD_NEXT;
      if (cmd == scgt_pkg::CMD_CLEAR) used_codes.delete();
      send_command(cmd, pick_code(), pick_glyph());
    end
  endtask

  initial begin
    error_count = 0;
    tbl_count = 0;
    idle_enable = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);
    drain();
    test_fill_table();
    send_command(scgt_pkg::CMD_CLEAR, 32'd0, 16'd0);
    used_codes.delete();
    test_random(350);
    idle_enable = 1'b0;
    test_random(200);
    drain();
    repeat (60) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
